>>> rtl/s2da_pkg.sv
// ----------------------------------------------------------------------------
// s2da_pkg: shared types and constants
// Character codes, back-end state encoding and the divide-by-ten step table
// used by the decimal text converter.
// ----------------------------------------------------------------------------
package s2da_pkg;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // nibbles divided per cycle and the bits they cover
    localparam int STEP_NIBS = 8;
    localparam int CHUNK_W   = STEP_NIBS * 4;

    // {remainder, nibble} is always below 160
    localparam int DIV_TAB_DEPTH = 160;

    // entry: {quotient[3:0], remainder[3:0]} of index / 10
    typedef logic [7:0] t_div_tab [DIV_TAB_DEPTH];

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGIT,
        S_NL
    } t_back_state;

    function automatic t_div_tab f_div_tab();
        t_div_tab   tab;
        logic [3:0] q;
        logic [3:0] r;
        q = '0;
        r = '0;
        for (int t = 0; t < DIV_TAB_DEPTH; t++) begin
            tab[t] = {q, r};
            if (r == 4'd9) begin
                r = '0;
                q = q + 4'd1;
            end else begin
                r = r + 4'd1;
            end
        end
        return tab;
    endfunction

    localparam t_div_tab DIV_TAB = f_div_tab();

endpackage

>>> rtl/s2da_in_if.sv
// ----------------------------------------------------------------------------
// s2da_in_if: input item channel
// Valid/ready channel carrying one signed integer per item.
// ----------------------------------------------------------------------------
interface s2da_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/s2da_out_if.sv
// ----------------------------------------------------------------------------
// s2da_out_if: output byte channel
// Valid/ready channel carrying one text byte and its end-of-run flag.
// ----------------------------------------------------------------------------
interface s2da_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last;

    modport source (output valid, output text_byte, output last, input ready);
    modport sink   (input valid, input text_byte, input last, output ready);
endinterface

>>> rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal text
// Each item is divided by ten digit by digit, P = ceil(VALUE_BITS/32) divide
//   passes per digit; its first byte leaves once all its digits are found.
// The engine converts one item at a time; the input stage and queue can take
//   new items before it is through with the last one.
// Reset: synchronous, active low; clears the handshake and sequencing state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s2da_in_if.sink    i_in,
    s2da_out_if.source o_out
);

    logic                push_valid;
    logic                push_ready;
    logic [VALUE_BITS:0] push_data;
    logic                pop_valid;
    logic                pop_ready;
    logic [VALUE_BITS:0] pop_data;

    s2da_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    s2da_queue #(
        .DATA_W (VALUE_BITS + 1)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    s2da_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .o_q_ready (pop_ready),
        .i_q_data  (pop_data),
        .o_out     (o_out)
    );

endmodule

>>> rtl/s2da_front.sv
// ----------------------------------------------------------------------------
// s2da_front: input stage
// Accepts an item, splits it into sign and magnitude and holds the result
// in a register until the queue takes it.
// ----------------------------------------------------------------------------
module s2da_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    s2da_in_if.sink             i_in,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output logic [VALUE_BITS:0] o_push_data
);

    logic                  r_valid;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  n_valid;
    logic                  accept;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;

    assign i_in.ready = !r_valid || i_push_ready;
    assign accept     = i_in.valid && i_in.ready;

    // most negative value wraps to 2^(n-1), which is right as unsigned
    assign in_neg = i_in.value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~i_in.value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_in.value;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= in_neg;
            r_mag <= in_mag;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = {r_neg, r_mag};

endmodule

>>> rtl/s2da_queue.sv
// ----------------------------------------------------------------------------
// s2da_queue: two-entry queue
// Decouples the input stage from the conversion engine.
// ----------------------------------------------------------------------------
module s2da_queue #(
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/s2da_back.sv
// ----------------------------------------------------------------------------
// s2da_back: conversion engine
// Peels decimal digits off the magnitude, least significant first, then
// sends a minus sign if negative, digits (most significant first) and
// newline through an output register.
// ----------------------------------------------------------------------------
module s2da_back
    import s2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  logic [VALUE_BITS:0] i_q_data,
    s2da_out_if.source          o_out
);

    localparam int PASSES     = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int WORK_W     = PASSES * CHUNK_W;
    localparam int PASS_W     = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int MAX_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    t_back_state         r_state, n_state;
    logic [WORK_W-1:0]   r_work, n_work;
    logic [3:0]          r_rem, n_rem;
    logic [PASS_W-1:0]   r_pass, n_pass;
    logic                r_neg, n_neg;
    logic [CNT_W-1:0]    r_nd, n_nd;
    logic                r_ov, n_ov;
    logic [7:0]          r_byte, n_byte;
    logic                r_last, n_last;
    logic [3:0]          r_dig [MAX_DIGITS];

    logic [3:0]          rem_chain [STEP_NIBS+1];
    logic [7:0]          div_ent [STEP_NIBS];
    logic [CHUNK_W-1:0]  div_q;
    logic [WORK_W-1:0]   div_work;
    logic [3:0]          div_rem;

    logic                slot_free;
    logic                emit;
    logic [7:0]          e_byte;
    logic                e_last;
    logic                dig_we;
    logic [CNT_W-1:0]    nd_dec;

    // long division of the top chunk by ten, one nibble per table step
    always_comb begin
        rem_chain[0] = r_rem;
        for (int k = 0; k < STEP_NIBS; k++) begin
            div_ent[k] = DIV_TAB[{rem_chain[k], r_work[WORK_W-1-4*k -: 4]}];
            div_q[CHUNK_W-1-4*k -: 4] = div_ent[k][7:4];
            rem_chain[k+1] = div_ent[k][3:0];
        end
    end

    assign div_rem  = rem_chain[STEP_NIBS];
    // after all passes the work register holds the quotient
    assign div_work = (r_work << CHUNK_W) | WORK_W'(div_q);
    assign nd_dec   = r_nd - CNT_W'(1);

    assign slot_free = !r_ov || o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_work    = r_work;
        n_rem     = r_rem;
        n_pass    = r_pass;
        n_neg     = r_neg;
        n_nd      = r_nd;
        o_q_ready = 1'b0;
        emit      = 1'b0;
        e_byte    = CH_NEWLINE;
        e_last    = 1'b0;
        dig_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_neg   = i_q_data[VALUE_BITS];
                    n_work  = WORK_W'(i_q_data[VALUE_BITS-1:0]);
                    n_rem   = '0;
                    n_pass  = '0;
                    n_nd    = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_work = div_work;
                n_rem  = div_rem;
                if (r_pass == PASS_W'(PASSES - 1)) begin
                    dig_we = 1'b1;
                    n_nd   = r_nd + CNT_W'(1);
                    n_rem  = '0;
                    n_pass = '0;
                    // zero still yields its single digit on the first round
                    if (div_work == '0) begin
                        n_state = r_neg ? S_SIGN : S_DIGIT;
                    end
                end else begin
                    n_pass = r_pass + PASS_W'(1);
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = CH_MINUS;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_byte = CH_ZERO + {4'b0000, r_dig[nd_dec[IDX_W-1:0]]};
                    n_nd   = nd_dec;
                    if (r_nd == CNT_W'(1)) begin
                        n_state = S_NL;
                    end
                end
            end
            S_NL: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = CH_NEWLINE;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ov   = r_ov;
        n_byte = r_byte;
        n_last = r_last;
        if (slot_free) begin
            n_ov = emit;
            if (emit) begin
                n_byte = e_byte;
                n_last = e_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pass  <= '0;
            r_nd    <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pass  <= n_pass;
            r_nd    <= n_nd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_byte <= n_byte;
        r_last <= n_last;
        if (dig_we) begin
            r_dig[r_nd[IDX_W-1:0]] <= div_rem;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.text_byte = r_byte;
    assign o_out.last      = r_last;

endmodule

>>> test/signed_int_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: testbench for the decimal text converter
// Sends signed integers, first from a directed table and then at random, under
// several idle and stall mixes and a long output hold, and checks every text
// byte and end flag against the table text or a local decimal conversion model.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test
    import s2da_pkg::*;
();

    localparam int VALUE_BITS   = 32;
    localparam int TEXT_BYTES   = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300_000;
    localparam int PHASE_ITEMS  = 80;

    localparam int SEND_IDLE_PCT  [4] = '{0, 47, 0, 35};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 47, 35};

    localparam int unsigned POW10 [10] = '{
        1, 10, 100, 1_000, 10_000, 100_000, 1_000_000, 10_000_000,
        100_000_000, 1_000_000_000
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
    } t_text_item;

    // text left all zero means the row is checked against the local model
    typedef struct packed {
        logic [VALUE_BITS-1:0]   value;
        logic [TEXT_BYTES*8-1:0] text;
    } t_row;

    localparam int ROW_COUNT = 22;
    localparam t_row DIRECTED [ROW_COUNT] = '{
        '{32'h0000_0000, "0"},
        '{32'h8000_0000, "-2147483648"},
        '{32'h7FFF_FFFF, "2147483647"},
        '{32'h8000_0001, "-2147483647"},
        '{32'hFFFF_FFFF, "-1"},
        '{32'h0000_0001, "1"},
        '{32'h0000_0009, "9"},
        '{32'hFFFF_FFF7, "-9"},
        '{32'h0000_000A, "10"},
        '{32'h0000_0000, '0},
        '{32'h0000_0063, '0},
        '{32'h0000_0064, '0},
        '{32'hFFFF_FF9C, '0},
        '{32'd999_999_999, '0},
        '{32'd1_000_000_000, '0},
        '{-32'sd1_000_000_000, '0},
        '{-32'sd999_999_999, '0},
        '{32'h5555_5555, '0},
        '{32'hAAAA_AAAA, '0},
        '{32'h7FFF_FFFE, '0},
        '{32'h8000_0002, '0},
        '{32'd1_234_567_890, '0}
    };

    logic i_clk;
    logic i_rst_n;

    s2da_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
    s2da_out_if                           out_ch ();

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_text_item  pending_text [$];
    t_text_item  oldest_text;
    int          error_count;
    int unsigned cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requested;
    int          hold_served;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // decimal text of one value: optional minus, digits msd first, newline
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS:0] magnitude;
        logic [3:0]          digits [$];
        magnitude = value[VALUE_BITS-1] ? {1'b0, ~value} + 1'b1
                                        : {1'b0, value};
        do begin
            digits.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (value[VALUE_BITS-1]) begin
            pending_text.push_back(t_text_item'{CH_MINUS, 1'b0});
        end
        foreach (digits[d]) begin
            pending_text.push_back(t_text_item'{CH_ZERO + 8'(digits[d]), 1'b0});
        end
        pending_text.push_back(t_text_item'{CH_NEWLINE, 1'b1});
    endfunction

    // entered just after a rising edge, returns just after the accepting one
    task automatic send_value(input logic [VALUE_BITS-1:0] value,
                              input logic [TEXT_BYTES*8-1:0] text);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        if (text != '0) begin
            for (int b = TEXT_BYTES - 1; b >= 0; b--) begin
                if (text[b*8 +: 8] != 8'h00) begin
                    pending_text.push_back(t_text_item'{text[b*8 +: 8], 1'b0});
                end
            end
            pending_text.push_back(t_text_item'{CH_NEWLINE, 1'b1});
        end else begin
            queue_decimal_text(value);
        end
    endtask

    task automatic send_random(input int count);
        logic [VALUE_BITS-1:0] magnitude;
        logic [VALUE_BITS-1:0] value;
        int unsigned           ndig;
        for (int k = 0; k < count; k++) begin
            ndig = $urandom_range(1, 9);
            case ($urandom_range(0, 4))
                0: begin
                    value = $urandom();
                end
                1: begin
                    value = VALUE_BITS'(int'($urandom_range(0, 40)) - 20);
                end
                2: begin
                    // random digit count, random content
                    magnitude = $urandom_range(POW10[ndig] - 1, POW10[ndig-1]);
                    value = $urandom_range(0, 1) ? -magnitude : magnitude;
                end
                3: begin
                    // around a power of ten, where the digit count changes
                    magnitude = POW10[ndig] + $urandom_range(0, 2) - 1;
                    value = $urandom_range(0, 1) ? -magnitude : magnitude;
                end
                default: begin
                    value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                 : 32'h7FFF_FFFF - $urandom_range(0, 3);
                end
            endcase
            send_value(value, '0);
        end
    endtask

    task automatic idle_until_drained();
        do begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end while (pending_text.size() != 0);
    endtask

    // output side: random stalls plus long holds asked for by the stimulus
    initial begin
        int hold_left;
        hold_left = 0;
        hold_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requested) begin
                hold_served = hold_requested;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_text.size() == 0) begin
                $error("unexpected item: text_byte 8'h%02h, last %0b",
                       out_ch.text_byte, out_ch.last);
                error_count++;
            end else begin
                oldest_text = pending_text.pop_front();
                if (out_ch.text_byte !== oldest_text.text_byte) begin
                    $error("text_byte: expected 8'h%02h, actual 8'h%02h",
                           oldest_text.text_byte, out_ch.text_byte);
                    error_count++;
                end
                if (out_ch.last !== oldest_text.last) begin
                    $error("last: expected %0b, actual %0b",
                           oldest_text.last, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requested = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < ROW_COUNT; r++) begin
            send_value(DIRECTED[r].value, DIRECTED[r].text);
        end

        // long output hold while items keep coming, then a full drain
        hold_requested++;
        send_random(30);
        idle_until_drained();
        send_random(10);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            send_random(PHASE_ITEMS);
        end

        recv_stall_pct = 0;
        idle_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/s2da_pkg.sv
rtl/s2da_in_if.sv
rtl/s2da_out_if.sv
rtl/s2da_front.sv
rtl/s2da_queue.sv
rtl/s2da_back.sv
rtl/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_test.sv
